// ===== sv/pit_pkg.sv =====
// Shared widths, stage counts and payload types for the point-in-triangle test.
package pit_pkg;

  localparam int COORD_W = 16;                   // coordinate width, 8 to 32
  localparam int DIFF_W  = COORD_W + 1;          // edge vector component
  localparam int SQ_W    = 2 * DIFF_W;           // one component product
  localparam int DOT_W   = SQ_W + 2;             // sum of three products
  localparam int HALF_W  = (DOT_W + 1) / 2;      // low slice of a dot product
  localparam int HIGH_W  = DOT_W - HALF_W;       // signed high slice
  localparam int PROD_W  = 2 * DOT_W;            // product of two dot products
  localparam int XY_W    = PROD_W + 1;           // x, y and the determinant
  localparam int Z_W     = PROD_W + 3;           // x + y - det

  localparam int DOT_STAGES = 3;
  localparam int MUL_STAGES = 2;
  localparam int DEC_STAGES = 2;
  localparam int LATENCY    = DOT_STAGES + MUL_STAGES + DEC_STAGES;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] a;
    logic signed [DOT_W-1:0] b;
    logic signed [DOT_W-1:0] c;
    logic signed [DOT_W-1:0] d;
    logic signed [DOT_W-1:0] e;
  } dots_t;

endpackage

// ===== sv/pit_in_if.sv =====
// Query channel: test point and three triangle vertices.
interface pit_in_if import pit_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic signed [COORD_W-1:0] vert_a_x;
  logic signed [COORD_W-1:0] vert_a_y;
  logic signed [COORD_W-1:0] vert_a_z;
  logic signed [COORD_W-1:0] vert_b_x;
  logic signed [COORD_W-1:0] vert_b_y;
  logic signed [COORD_W-1:0] vert_b_z;
  logic signed [COORD_W-1:0] vert_c_x;
  logic signed [COORD_W-1:0] vert_c_y;
  logic signed [COORD_W-1:0] vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

// ===== sv/pit_out_if.sv =====
// Result channel: one inside flag per query.
interface pit_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ===== sv/pit_dot_stage.sv =====
// Edge vectors, component products and the five dot products (three stages).
module pit_dot_stage import pit_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  vec3_t pt,
  input  vec3_t va,
  input  vec3_t vb,
  input  vec3_t vc,
  output dots_t dots
);

  logic signed [DIFF_W-1:0] u [3];
  logic signed [DIFF_W-1:0] v [3];
  logic signed [DIFF_W-1:0] w [3];

  logic signed [SQ_W-1:0] puu [3];
  logic signed [SQ_W-1:0] puv [3];
  logic signed [SQ_W-1:0] pvv [3];
  logic signed [SQ_W-1:0] pwu [3];
  logic signed [SQ_W-1:0] pwv [3];

  // Stage 1: edge vectors from vertex A
  always_ff @(posedge clk) begin
    if (en) begin
      u[0] <= DIFF_W'(vb.x) - DIFF_W'(va.x);
      u[1] <= DIFF_W'(vb.y) - DIFF_W'(va.y);
      u[2] <= DIFF_W'(vb.z) - DIFF_W'(va.z);
      v[0] <= DIFF_W'(vc.x) - DIFF_W'(va.x);
      v[1] <= DIFF_W'(vc.y) - DIFF_W'(va.y);
      v[2] <= DIFF_W'(vc.z) - DIFF_W'(va.z);
      w[0] <= DIFF_W'(pt.x) - DIFF_W'(va.x);
      w[1] <= DIFF_W'(pt.y) - DIFF_W'(va.y);
      w[2] <= DIFF_W'(pt.z) - DIFF_W'(va.z);
    end
  end

  // Stage 2: one multiplier per component and dot product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        puu[k] <= u[k] * u[k];
        puv[k] <= u[k] * v[k];
        pvv[k] <= v[k] * v[k];
        pwu[k] <= w[k] * u[k];
        pwv[k] <= w[k] * v[k];
      end
    end
  end

  // Stage 3: sum the three components
  always_ff @(posedge clk) begin
    if (en) begin
      dots.a <= DOT_W'(puu[0]) + DOT_W'(puu[1]) + DOT_W'(puu[2]);
      dots.b <= DOT_W'(puv[0]) + DOT_W'(puv[1]) + DOT_W'(puv[2]);
      dots.c <= DOT_W'(pvv[0]) + DOT_W'(pvv[1]) + DOT_W'(pvv[2]);
      dots.d <= DOT_W'(pwu[0]) + DOT_W'(pwu[1]) + DOT_W'(pwu[2]);
      dots.e <= DOT_W'(pwv[0]) + DOT_W'(pwv[1]) + DOT_W'(pwv[2]);
    end
  end

endmodule

// ===== sv/pit_wide_mul.sv =====
// Signed dot-product multiplier split into four partial products over two stages.
module pit_wide_mul import pit_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DOT_W-1:0]  a,
  input  logic signed [DOT_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  logic signed [HALF_W:0]   a_lo;
  logic signed [HALF_W:0]   b_lo;
  logic signed [HIGH_W-1:0] a_hi;
  logic signed [HIGH_W-1:0] b_hi;

  logic signed [2*HALF_W+1:0]      p_ll;
  logic signed [HALF_W+HIGH_W:0]   p_lh;
  logic signed [HALF_W+HIGH_W:0]   p_hl;
  logic signed [2*HIGH_W-1:0]      p_hh;
  logic signed [PROD_W-1:0]        p_next;

  // low slices are unsigned magnitudes, high slices carry the sign
  assign a_lo = $signed({1'b0, a[HALF_W-1:0]});
  assign b_lo = $signed({1'b0, b[HALF_W-1:0]});
  assign a_hi = a[DOT_W-1:HALF_W];
  assign b_hi = b[DOT_W-1:HALF_W];

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll <= a_lo * b_lo;
      p_lh <= a_lo * b_hi;
      p_hl <= a_hi * b_lo;
      p_hh <= a_hi * b_hi;
    end
  end

  assign p_next = (PROD_W'(p_hh) <<< (2 * HALF_W))
                + ((PROD_W'(p_lh) + PROD_W'(p_hl)) <<< HALF_W)
                + PROD_W'(p_ll);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= p_next;
    end
  end

endmodule

// ===== sv/pit_decide.sv =====
// Barycentric numerators, determinant and the final sign test (two stages).
module pit_decide import pit_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [PROD_W-1:0] ac,
  input  logic signed [PROD_W-1:0] bb,
  input  logic signed [PROD_W-1:0] dc,
  input  logic signed [PROD_W-1:0] eb,
  input  logic signed [PROD_W-1:0] ea,
  input  logic signed [PROD_W-1:0] db,
  output logic                     hit
);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [XY_W-1:0] det;
  logic signed [Z_W-1:0]  z_next;

  always_ff @(posedge clk) begin
    if (en) begin
      x   <= XY_W'(dc) - XY_W'(eb);
      y   <= XY_W'(ea) - XY_W'(db);
      det <= XY_W'(ac) - XY_W'(bb);
    end
  end

  assign z_next = Z_W'(x) + Z_W'(y) - Z_W'(det);

  // hit: z negative, x and y not negative
  always_ff @(posedge clk) begin
    if (en) begin
      hit <= z_next[Z_W-1] & ~x[XY_W-1] & ~y[XY_W-1];
    end
  end

endmodule

// ===== sv/point_in_triangle_test.sv =====
// Top level of the exact barycentric point-in-triangle test.
//
// Each query beat carries a test point P and triangle vertices A, B, C as
// signed COORD_W-bit coordinates; each result beat carries one flag,
// inside_res, set when P projects inside the triangle. The block
// forms u = B - A, v = C - A, w = P - A, the dot products a = u.u, b = u.v,
// c = v.v, d = w.u, e = w.v, then x = dc - eb, y = ea - db and
// z = x + y - (ac - bb), and reports z < 0 with x >= 0 and y >= 0. All
// arithmetic is exact integer math at full width, so scaling the
// coordinates never changes the answer; degenerate triangles give 0.
// A new query is accepted every clock as long as results are taken: the
// pipeline is seven register stages deep (three for the edge vectors,
// component products and dot sums, two for the split 2-by-2 partial-product
// multipliers, two for the numerators and sign test). The last stage
// doubles as the output register. When a finished result is not taken,
// every stage holds, empty ones included, and query.ready drops in the
// same cycle, so a waiting result blocks new queries until it is taken;
// bubbles are not squeezed out. There is no state between queries.
module point_in_triangle_test import pit_pkg::*; (
  input logic      clk,
  input logic      rst,
  pit_in_if.sink   query,
  pit_out_if.source result
);

  logic               adv;
  logic [LATENCY-1:0] vld;

  vec3_t pt;
  vec3_t va;
  vec3_t vb;
  vec3_t vc;
  dots_t dots;

  logic signed [PROD_W-1:0] ac;
  logic signed [PROD_W-1:0] bb;
  logic signed [PROD_W-1:0] dc;
  logic signed [PROD_W-1:0] eb;
  logic signed [PROD_W-1:0] ea;
  logic signed [PROD_W-1:0] db;
  logic                     hit;

  // Advance the pipeline unless the output holds a beat nobody takes.
  assign adv         = ~vld[LATENCY-1] | result.ready;
  assign query.ready = adv;

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LATENCY-2:0], query.valid};
    end
  end

  assign pt = '{x: query.point_x,  y: query.point_y,  z: query.point_z};
  assign va = '{x: query.vert_a_x, y: query.vert_a_y, z: query.vert_a_z};
  assign vb = '{x: query.vert_b_x, y: query.vert_b_y, z: query.vert_b_z};
  assign vc = '{x: query.vert_c_x, y: query.vert_c_y, z: query.vert_c_z};

  pit_dot_stage u_dot (
    .clk  (clk),
    .en   (adv),
    .pt   (pt),
    .va   (va),
    .vb   (vb),
    .vc   (vc),
    .dots (dots)
  );

  // Six products of dot products, one split multiplier each.
  pit_wide_mul u_mul_ac (.clk(clk), .en(adv), .a(dots.a), .b(dots.c), .p(ac));
  pit_wide_mul u_mul_bb (.clk(clk), .en(adv), .a(dots.b), .b(dots.b), .p(bb));
  pit_wide_mul u_mul_dc (.clk(clk), .en(adv), .a(dots.d), .b(dots.c), .p(dc));
  pit_wide_mul u_mul_eb (.clk(clk), .en(adv), .a(dots.e), .b(dots.b), .p(eb));
  pit_wide_mul u_mul_ea (.clk(clk), .en(adv), .a(dots.e), .b(dots.a), .p(ea));
  pit_wide_mul u_mul_db (.clk(clk), .en(adv), .a(dots.d), .b(dots.b), .p(db));

  pit_decide u_decide (
    .clk (clk),
    .en  (adv),
    .ac  (ac),
    .bb  (bb),
    .dc  (dc),
    .eb  (eb),
    .ea  (ea),
    .db  (db),
    .hit (hit)
  );

  assign result.valid      = vld[LATENCY-1];
  assign result.inside_res = hit;

  // A stalled output must hold back new queries.
  a_stall_blocks_query: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !query.ready)
    else $error("query accepted while output stalled");

  // The first valid bit records exactly what was offered on an advance.
  a_valid_enters: assert property (@(posedge clk) disable iff (rst)
    adv |=> (vld[0] == $past(query.valid)))
    else $error("valid bit lost or invented at pipeline entry");

  // A held pipeline keeps every valid bit in place.
  a_hold_keeps_valid: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

endmodule
